// ----- rtl/i2r_pkg.sv -----
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types and constants of the integer to radix digits block.
// ----------------------------------------------------------------------------
package i2r_pkg;

	localparam int NUM_W         = 32;
	localparam int MAX_DIGITS    = 32;
	localparam int CNT_W         = 6;
	localparam int REM_W         = 5;
	localparam int BITS_PER_STEP = 8;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 64;

	localparam logic [1:0] STEP_LAST = 2'd3;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;

	localparam logic [4:0] MIN_RADIX = 5'd2;

	localparam logic [4:0]  RADIX_RST       = 5'd10;
	localparam logic [63:0] DIGITS_LOW_RST  = 64'h3736353433323130;
	localparam logic [63:0] DIGITS_HIGH_RST = 64'h0000000000003938;

	localparam logic [1:0] REG_RADIX       = 2'd0;
	localparam logic [1:0] REG_DIGITS_LOW  = 2'd1;
	localparam logic [1:0] REG_DIGITS_HIGH = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_sign;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic last_step;
		logic quot_zero;
		logic neg;
		logic nd_one;
	} status_t;

endpackage

// ----- rtl/integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Renders a signed 32-bit number as text in a configured radix and alphabet.
// ----------------------------------------------------------------------------
//  channel   signals                                   transfer
//  input     start, busy, number                       start & !busy
//  result    strobe, character, last                   strobe (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata,     psel & penable & pwrite
//            prdata, pready
//
//  each digit is divided out at 8 quotient bits per cycle,
//  then the characters are emitted in turn, a minus sign first for a negative
//  number; strobes follow the sign and pop commands in the next cycle
//  an item with an invalid alphabet is accepted and busy never rises
//  reset restores radix 10 with alphabet 0..9
//  the receiver cannot stall, so every strobe is a transfer
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
	parameter int MAX_RADIX = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [i2r_pkg::NUM_W-1:0] number,
	output logic                             strobe,
	output logic [7:0]                       character,
	output logic                             last,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [i2r_pkg::ADDR_W-1:0]       paddr,
	input  logic [i2r_pkg::DATA_W-1:0]       pwdata,
	output logic [i2r_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);
	import i2r_pkg::*;

	logic [4:0]  radix;
	logic [63:0] digits_low;
	logic [63:0] digits_high;
	logic        alpha_ok;
	cmd_t        cmd;
	status_t     status;

	i2r_regs #(
		.MAX_RADIX (MAX_RADIX)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.radix       (radix),
		.digits_low  (digits_low),
		.digits_high (digits_high),
		.alpha_ok    (alpha_ok)
	);

	i2r_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.alpha_ok (alpha_ok),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	i2r_dp #(
		.MAX_RADIX (MAX_RADIX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.number      (number),
		.radix       (radix),
		.digits_low  (digits_low),
		.digits_high (digits_high),
		.status      (status),
		.strobe      (strobe),
		.character   (character),
		.last        (last)
	);

endmodule

// ----- rtl/i2r_regs.sv -----
// ----------------------------------------------------------------------------
// i2r_regs
// Configuration registers on the APB-style port and the alphabet check.
// ----------------------------------------------------------------------------
module i2r_regs #(
	parameter int MAX_RADIX = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [i2r_pkg::ADDR_W-1:0]  paddr,
	input  logic [i2r_pkg::DATA_W-1:0]  pwdata,
	output logic [i2r_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [4:0]                  radix,
	output logic [63:0]                 digits_low,
	output logic [63:0]                 digits_high,
	output logic                        alpha_ok
);
	import i2r_pkg::*;

	logic [4:0]   radix_q;
	logic [63:0]  digits_low_q;
	logic [63:0]  digits_high_q;
	logic [127:0] alpha;
	logic         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign alpha  = {digits_high_q, digits_low_q};

	// low address bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RST;
			digits_low_q  <= DIGITS_LOW_RST;
			digits_high_q <= DIGITS_HIGH_RST;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_RADIX:       radix_q       <= pwdata[4:0];
				REG_DIGITS_LOW:  digits_low_q  <= pwdata;
				REG_DIGITS_HIGH: digits_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_RADIX:       prdata = {59'd0, radix_q};
			REG_DIGITS_LOW:  prdata = digits_low_q;
			REG_DIGITS_HIGH: prdata = digits_high_q;
			default:         prdata = '0;
		endcase
	end

	// radix range check, and a pairwise check over the characters in use that also rejects minus and plus
	always_comb begin
		logic ok;
		logic [7:0] ci;
		ok = (radix_q >= MIN_RADIX) && (radix_q <= 5'(MAX_RADIX));
		for (int i = 0; i < 16; i++) begin
			ci = alpha[i*8 +: 8];
			if (5'(i) < radix_q) begin
				if (ci == CHAR_MINUS || ci == CHAR_PLUS)
					ok = 1'b0;
				for (int j = i + 1; j < 16; j++) begin
					if (5'(j) < radix_q && alpha[j*8 +: 8] == ci)
						ok = 1'b0;
				end
			end
		end
		alpha_ok = ok;
	end

	assign radix       = radix_q;
	assign digits_low  = digits_low_q;
	assign digits_high = digits_high_q;

endmodule

// ----- rtl/i2r_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2r_ctrl
// Sequencer: load, divide digit by digit, then emit the sign of a negative number and the digits.
// ----------------------------------------------------------------------------
module i2r_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              alpha_ok,
	input  i2r_pkg::status_t  status,
	output i2r_pkg::cmd_t     cmd,
	output logic              busy
);
	import i2r_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && alpha_ok)
					state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (status.last_step && status.quot_zero)
					state_nx = status.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.nd_one)
					state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DIV:  cmd.div_step  = 1'b1;
			ST_SIGN: cmd.emit_sign = 1'b1;
			ST_EMIT: cmd.pop       = 1'b1;
			default: busy = 1'b0;
		endcase
	end

endmodule

// ----- rtl/i2r_dp.sv -----
// ----------------------------------------------------------------------------
// i2r_dp
// Datapath: magnitude divider, digit stack and output register.
// ----------------------------------------------------------------------------
module i2r_dp #(
	parameter int MAX_RADIX = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  i2r_pkg::cmd_t               cmd,
	input  logic signed [i2r_pkg::NUM_W-1:0] number,
	input  logic [4:0]                  radix,
	input  logic [63:0]                 digits_low,
	input  logic [63:0]                 digits_high,
	output i2r_pkg::status_t            status,
	output logic                        strobe,
	output logic [7:0]                  character,
	output logic                        last
);
	import i2r_pkg::*;

	localparam int DW = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;

	logic [NUM_W-1:0] mag_q;
	logic [NUM_W-1:0] mag_nx;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem_nx;
	logic [1:0]       step_q;
	logic [CNT_W-1:0] nd_q;
	logic             neg_q;
	logic [DW-1:0]    stack_q [MAX_DIGITS];
	logic [127:0]     alpha;
	logic [3:0]       top_idx;
	logic             push;
	logic             strobe_q;
	logic [7:0]       character_q;
	logic             last_q;

	assign alpha   = {digits_high, digits_low};
	assign top_idx = 4'(stack_q[0]);
	assign push    = cmd.div_step && (step_q == STEP_LAST);

	// eight restoring steps per cycle, quotient bits shift in at the bottom
	always_comb begin
		logic [REM_W-1:0] r;
		logic [NUM_W-1:0] m;
		r = rem_q;
		m = mag_q;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			r = {r[REM_W-2:0], m[NUM_W-1]};
			m = {m[NUM_W-2:0], 1'b0};
			if (r >= radix) begin
				r    = r - radix;
				m[0] = 1'b1;
			end
		end
		rem_nx = r;
		mag_nx = m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			nd_q   <= '0;
			neg_q  <= 1'b0;
		end else if (cmd.load) begin
			step_q <= '0;
			nd_q   <= '0;
			neg_q  <= number[NUM_W-1];
		end else if (cmd.div_step) begin
			step_q <= step_q + 2'd1;
			if (push)
				nd_q <= nd_q + CNT_W'(1);
		end else if (cmd.pop) begin
			nd_q <= nd_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= number[NUM_W-1] ? (~number + NUM_W'(1)) : number;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			mag_q <= mag_nx;
			rem_q <= push ? REM_W'(0) : rem_nx;
		end
	end

	// digit stack: push at the top while dividing, pop from the top while emitting
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[0] <= rem_nx[DW-1:0];
			for (int i = 1; i < MAX_DIGITS; i++)
				stack_q[i] <= stack_q[i-1];
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++)
				stack_q[i] <= stack_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_sign | cmd.pop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			character_q <= CHAR_MINUS;
			last_q      <= 1'b0;
		end else if (cmd.pop) begin
			character_q <= alpha[top_idx*8 +: 8];
			last_q      <= (nd_q == CNT_W'(1));
		end
	end

	assign status.last_step = (step_q == STEP_LAST);
	assign status.quot_zero = (mag_nx == '0);
	assign status.neg       = neg_q;
	assign status.nd_one    = (nd_q == CNT_W'(1));

	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

endmodule
